FILE: rtl/lpma_pkg.sv
// ----------------------------------------------------------------------------
// lpma_pkg: shared types and constants of the light palette allocator
// Item modes, register indexes, distance width and reset presets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpma_pkg;

   // Component and field widths
   localparam int COMP_W     = 8;
   localparam int COLOR_W    = 3 * COMP_W;
   localparam int DIST_W     = 10;
   localparam int COUNT_W    = 8;
   localparam int CSR_DATA_W = 10;

   // Search start: a slot must beat this to win over slot 0
   localparam logic [DIST_W-1:0]  START_DIST = 10'd1020;
   localparam logic [DIST_W-1:0]  RESET_TOL  = 10'd3;
   localparam logic [COMP_W-1:0]  RESET_MULT = 8'd28;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'd255;

   typedef enum logic [1:0] {
      MODE_REQUEST = 2'd0,
      MODE_FREE    = 2'd1,
      MODE_CLEAR   = 2'd2
   } mode_type;

   typedef enum logic {
      CSR_MATCH_TOLERANCE  = 1'b0,
      CSR_DEFAULT_MULTIPLIER = 1'b1
   } csr_index_type;

   // Reset color of a slot; slots past the preset list start black
   function automatic logic [COLOR_W-1:0] preset_color(input int unsigned slot);
      logic [COLOR_W-1:0] color;
      case (slot)
         0:       color = {8'd255, 8'd255, 8'd255};
         1:       color = {8'd10,  8'd10,  8'd255};
         2:       color = {8'd255, 8'd250, 8'd20};
         3:       color = {8'd80,  8'd0,   8'd200};
         default: color = '0;
      endcase
      return color;
   endfunction

endpackage

FILE: rtl/light_palette_match_allocator.sv
// ----------------------------------------------------------------------------
// light_palette_match_allocator: palette slot matcher and allocator
// Usage:
//   req_* is a valid/ready channel carrying one item: a request for a slot
//   by color and multiplier, a free of one slot, or a clear of every count but slot 0's.
//   rsp_* is a valid/ready channel returning one item per input item: the
//   granted (or echoed) slot index and a created flag.
//   csr_* is a write-only register port (tolerance, default multiplier);
//   it must be written only while the block is idle; the block does not enforce this.
// Timing:
//   An item waits in the input register until it advances; then the slot
//   search, the state update and the result register load happen in one pass.
//   The item passes through the input register and then the result register,
//   which drives rsp_valid; throughput is one item per cycle while rsp_ready
//   stays high, set by the read-modify-write of the slot state.
// Reset:
//   Synchronous, active high. Slots return to their preset colors, every
//   multiplier to 28, every count to 0, registers to their reset values.
// Stall:
//   While rsp_ready is low the result holds, the input register holds its
//   item and req_ready drops once that register is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module light_palette_match_allocator
   import lpma_pkg::*;
#(
   parameter int SLOTS = 4
)
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_mode,
   input  logic [COMP_W-1:0]     req_red,
   input  logic [COMP_W-1:0]     req_green,
   input  logic [COMP_W-1:0]     req_blue,
   input  logic [COMP_W-1:0]     req_multiplier,
   input  logic [1:0]            req_free_index,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_slot_index,
   output logic                  rsp_created,

   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // Configuration registers
   logic [DIST_W-1:0]  tolerance_ff;
   logic [COMP_W-1:0]  default_mult_ff;

   // Input register
   logic               in_valid_ff;
   logic [1:0]         mode_ff;
   logic [COMP_W-1:0]  red_ff;
   logic [COMP_W-1:0]  green_ff;
   logic [COMP_W-1:0]  blue_ff;
   logic [COMP_W-1:0]  mult_req_ff;
   logic [1:0]         free_index_ff;

   // Result register
   logic               out_valid_ff;
   logic [1:0]         slot_ff;
   logic               created_ff;
   logic [1:0]         slot_in;
   logic               created_in;

   // Palette state
   logic [COLOR_W-1:0] color_ff [SLOTS];
   logic [COMP_W-1:0]  mult_ff  [SLOTS];
   logic [COUNT_W-1:0] count_ff [SLOTS];
   logic [COLOR_W-1:0] color_in [SLOTS];
   logic [COMP_W-1:0]  mult_in  [SLOTS];
   logic [COUNT_W-1:0] count_in [SLOTS];

   logic [DIST_W-1:0]  slot_dist [SLOTS];
   logic [IDX_W-1:0]   best_slot;
   logic [DIST_W-1:0]  best_dist;
   logic [IDX_W-1:0]   free_slot;
   logic               free_found;
   logic               reuse;
   logic               advance;

   // Move the held item through when the result register is empty or drains
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign rsp_valid      = out_valid_ff;
   assign rsp_slot_index = slot_ff;
   assign rsp_created    = created_ff;

   // ---------------------------------------------------------------------
   // Configuration writes
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff    <= RESET_TOL;
         default_mult_ff <= RESET_MULT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MATCH_TOLERANCE:    tolerance_ff    <= csr_wdata;
            CSR_DEFAULT_MULTIPLIER: default_mult_ff <= csr_wdata[COMP_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Input register: capture on accept, drop valid when the item advances
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         mode_ff       <= req_mode;
         red_ff        <= req_red;
         green_ff      <= req_green;
         blue_ff       <= req_blue;
         mult_req_ff   <= req_multiplier;
         free_index_ff <= req_free_index;
      end
   end

   // ---------------------------------------------------------------------
   // One distance unit per slot, all in parallel
   // ---------------------------------------------------------------------
   for (genvar s = 0; s < SLOTS; s++) begin : g_dist
      lpma_slot_dist u_dist (
         .req_red         (red_ff),
         .req_green       (green_ff),
         .req_blue        (blue_ff),
         .req_multiplier  (mult_req_ff),
         .slot_color      (color_ff[s]),
         .slot_multiplier (mult_ff[s]),
         .l1_dist         (slot_dist[s])
      );
   end

   // ---------------------------------------------------------------------
   // Best match (first strict minimum over slot 0 and slots in use)
   // and first free slot from 1 upward
   // ---------------------------------------------------------------------
   always_comb begin
      best_slot  = '0;
      best_dist  = START_DIST;
      free_slot  = '0;
      free_found = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if ((i == 0 || count_ff[i] != '0) && slot_dist[i] < best_dist) begin
            best_slot = IDX_W'(i);
            best_dist = slot_dist[i];
         end
      end
      for (int i = 1; i < SLOTS; i++) begin
         if (!free_found && count_ff[i] == '0) begin
            free_found = 1'b1;
            free_slot  = IDX_W'(i);
         end
      end
      // Reuse when close enough, or when the palette is full
      reuse = (best_dist < tolerance_ff) || !free_found;
   end

   // ---------------------------------------------------------------------
   // Next palette state and result
   // ---------------------------------------------------------------------
   always_comb begin
      slot_in    = '0;
      created_in = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         color_in[i] = color_ff[i];
         mult_in[i]  = mult_ff[i];
         count_in[i] = count_ff[i];
      end
      case (mode_ff)
         MODE_REQUEST: begin
            if (reuse) begin
               slot_in = 2'(best_slot);
               for (int i = 0; i < SLOTS; i++) begin
                  if (IDX_W'(i) == best_slot && count_ff[i] != COUNT_MAX) begin
                     count_in[i] = count_ff[i] + 1'b1;
                  end
               end
            end else begin
               slot_in    = 2'(free_slot);
               created_in = 1'b1;
               for (int i = 0; i < SLOTS; i++) begin
                  if (IDX_W'(i) == free_slot) begin
                     color_in[i] = {red_ff, green_ff, blue_ff};
                     mult_in[i]  = (mult_req_ff != '0) ? mult_req_ff : default_mult_ff;
                     count_in[i] = COUNT_W'(1);
                  end
               end
            end
         end
         MODE_FREE: begin
            // Echo the index; an index past the palette changes nothing
            slot_in = free_index_ff;
            for (int i = 0; i < SLOTS; i++) begin
               if (int'(free_index_ff) == i && count_ff[i] != '0) begin
                  count_in[i] = count_ff[i] - 1'b1;
               end
            end
         end
         MODE_CLEAR: begin
            for (int i = 1; i < SLOTS; i++) begin
               count_in[i] = '0;
            end
         end
         default: ;
      endcase
   end

   // Commit the state update only when the item advances
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            color_ff[i] <= preset_color(i);
            mult_ff[i]  <= RESET_MULT;
            count_ff[i] <= '0;
         end
      end else if (advance) begin
         for (int i = 0; i < SLOTS; i++) begin
            color_ff[i] <= color_in[i];
            mult_ff[i]  <= mult_in[i];
            count_ff[i] <= count_in[i];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result register: load on advance, hold while the receiver stalls
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         slot_ff    <= slot_in;
         created_ff <= created_in;
      end
   end

endmodule

FILE: rtl/lpma_slot_dist.sv
// ----------------------------------------------------------------------------
// lpma_slot_dist: L1 distance between a requested light and one slot
// Sums the absolute component differences, plus the multiplier difference
// when the request asks for a multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpma_slot_dist
   import lpma_pkg::*;
(
   input  logic [COMP_W-1:0]  req_red,
   input  logic [COMP_W-1:0]  req_green,
   input  logic [COMP_W-1:0]  req_blue,
   input  logic [COMP_W-1:0]  req_multiplier,
   input  logic [COLOR_W-1:0] slot_color,
   input  logic [COMP_W-1:0]  slot_multiplier,
   output logic [DIST_W-1:0]  l1_dist
);

   function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
                                                  input logic [COMP_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   logic [COMP_W-1:0] diff_red;
   logic [COMP_W-1:0] diff_green;
   logic [COMP_W-1:0] diff_blue;
   logic [COMP_W-1:0] diff_mult;

   always_comb begin
      diff_red   = abs_diff(req_red,   slot_color[3*COMP_W-1:2*COMP_W]);
      diff_green = abs_diff(req_green, slot_color[2*COMP_W-1:COMP_W]);
      diff_blue  = abs_diff(req_blue,  slot_color[COMP_W-1:0]);
      // A zero multiplier means no preference: leave it out of the sum
      diff_mult  = (req_multiplier != '0) ? abs_diff(req_multiplier, slot_multiplier) : '0;
      l1_dist = DIST_W'(diff_red) + DIST_W'(diff_green) + DIST_W'(diff_blue)
              + DIST_W'(diff_mult);
   end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: light palette slot matcher and allocator
// Drives request, free, clear and unused-mode items through the valid/ready
// input channel and checks every returned slot index and created flag
// against a cycle-free palette predictor. Both channels stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import lpma_pkg::*;

   localparam int SLOTS        = 4;
   localparam int SEARCH_START = 1020;      // slot 0 wins unless beaten
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 4;         // extra wait after the last result
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct {
      logic [1:0] mode;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] mult;
      logic [1:0] free_idx;
   } palette_item_t;

   typedef struct packed {
      logic [1:0] slot;
      logic       created;
   } grant_t;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [1:0]            req_mode;
   logic [COMP_W-1:0]     req_red;
   logic [COMP_W-1:0]     req_green;
   logic [COMP_W-1:0]     req_blue;
   logic [COMP_W-1:0]     req_multiplier;
   logic [1:0]            req_free_index;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [1:0]            rsp_slot_index;
   logic                  rsp_created;
   logic                  csr_we;
   logic                  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   light_palette_match_allocator #(.SLOTS(SLOTS)) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .req_multiplier (req_multiplier),
      .req_free_index (req_free_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_slot_index (rsp_slot_index),
      .rsp_created    (rsp_created),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // Palette mirror: colors, multipliers, counts and the two settings
   logic [23:0] pal_color [SLOTS];
   logic [7:0]  pal_mult  [SLOTS];
   logic [7:0]  pal_count [SLOTS];
   logic [9:0]  tol_reg;
   logic [7:0]  dflt_mult;

   grant_t grant_q[$];        // grants awaiting their result item
   bit     no_idle;           // suppress random idling on both sides
   int     err_count;
   int     cycle_count;
   int     n_request, n_free, n_clear, n_unused, n_created, n_settings;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Abort a hung run; the limit is far above the slowest legal run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due",
                  cycle_count, grant_q.size());
         $display("light_palette_match_allocator test failed");
         $finish;
      end
   end

   // Result side: stall at random unless idling is suppressed
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ready <= no_idle || ($urandom_range(99) >= 9);
      end
   end

   // Compare each accepted result with the oldest outstanding grant
   always @(posedge clock) begin
      grant_t exp_g;
      if (!reset && rsp_valid && rsp_ready) begin
         if (grant_q.size() == 0) begin
            $error("result item with nothing outstanding: slot_index %0d created %0d",
                   rsp_slot_index, rsp_created);
            err_count++;
         end else begin
            exp_g = grant_q.pop_front();
            if (rsp_slot_index !== exp_g.slot) begin
               $error("slot_index mismatch: expected %0d, actual %0d",
                      exp_g.slot, rsp_slot_index);
               err_count++;
            end
            if (rsp_created !== exp_g.created) begin
               $error("created mismatch: expected %0d, actual %0d",
                      exp_g.created, rsp_created);
               err_count++;
            end
            if (exp_g.created)
               n_created++;
         end
      end
   end

   function automatic int abs_diff(int a, int b);
      return (a > b) ? a - b : b - a;
   endfunction

   // Return the palette to its power-up contents
   function automatic void reset_palette();
      pal_color[0] = {8'd255, 8'd255, 8'd255};
      pal_color[1] = {8'd10,  8'd10,  8'd255};
      pal_color[2] = {8'd255, 8'd250, 8'd20};
      pal_color[3] = {8'd80,  8'd0,   8'd200};
      for (int i = 0; i < SLOTS; i++) begin
         pal_mult[i]  = 8'd28;
         pal_count[i] = 8'd0;
      end
      tol_reg   = 10'd3;
      dflt_mult = 8'd28;
   endfunction

   // Apply one item to the palette mirror and return the grant it earns
   function automatic grant_t grant_slot(palette_item_t it);
      grant_t grant;
      int     best, best_d, d, free_slot;
      grant = '0;
      case (it.mode)
         MODE_REQUEST: begin
            best      = 0;
            best_d    = SEARCH_START;
            free_slot = SLOTS;
            // slot 0 always competes; others only while in use
            for (int i = 0; i < SLOTS; i++) begin
               if (i == 0 || pal_count[i] != 8'd0) begin
                  d = abs_diff(it.red,   pal_color[i][23:16]) +
                      abs_diff(it.green, pal_color[i][15:8]) +
                      abs_diff(it.blue,  pal_color[i][7:0]) +
                      ((it.mult != 8'd0) ? abs_diff(it.mult, pal_mult[i]) : 0);
                  if (d < best_d) begin
                     best   = i;
                     best_d = d;
                  end
               end
            end
            for (int i = SLOTS - 1; i >= 1; i--)
               if (pal_count[i] == 8'd0)
                  free_slot = i;
            if (best_d < int'(tol_reg) || free_slot == SLOTS) begin
               // reuse the winner, saturating its count
               if (pal_count[best] != 8'd255)
                  pal_count[best] = pal_count[best] + 8'd1;
               grant.slot = best[1:0];
            end else begin
               pal_color[free_slot] = {it.red, it.green, it.blue};
               pal_mult[free_slot]  = (it.mult != 8'd0) ? it.mult : dflt_mult;
               pal_count[free_slot] = 8'd1;
               grant.slot    = free_slot[1:0];
               grant.created = 1'b1;
            end
         end
         MODE_FREE: begin
            if (pal_count[it.free_idx] != 8'd0)
               pal_count[it.free_idx] = pal_count[it.free_idx] - 8'd1;
            grant.slot = it.free_idx;
         end
         MODE_CLEAR: begin
            for (int i = 1; i < SLOTS; i++)
               pal_count[i] = 8'd0;
         end
         default: ;
      endcase
      return grant;
   endfunction

   // Move a component by up to span steps either way, clamped to 0..255
   function automatic logic [7:0] nudge(logic [7:0] v, int span);
      int x;
      x = int'(v) + int'($urandom_range(2 * span)) - span;
      if (x < 0)
         x = 0;
      if (x > 255)
         x = 255;
      return x[7:0];
   endfunction

   // Mostly requests aimed near a slot's color, plus frees, clears and noise
   function automatic palette_item_t random_item();
      palette_item_t it;
      int            pick, k, span, mpick;
      pick = $urandom_range(99);
      k    = $urandom_range(SLOTS - 1);
      it.mode     = MODE_REQUEST;
      it.red      = 8'($urandom);
      it.green    = 8'($urandom);
      it.blue     = 8'($urandom);
      it.mult     = 8'($urandom);
      it.free_idx = 2'($urandom);
      if (pick < 50) begin
         span     = $urandom_range(6);
         mpick    = $urandom_range(2);
         it.red   = nudge(pal_color[k][23:16], span);
         it.green = nudge(pal_color[k][15:8], span);
         it.blue  = nudge(pal_color[k][7:0], span);
         if (mpick == 0)
            it.mult = 8'd0;
         else if (mpick == 1)
            it.mult = nudge(pal_mult[k], 3);
      end else if (pick < 65) begin
         // fully random request: fields stay as drawn
      end else if (pick < 85) begin
         it.mode = MODE_FREE;
      end else if (pick < 91) begin
         it.mode = MODE_CLEAR;
      end else if (pick < 95) begin
         it.mode = MODE_UNUSED;
      end else begin
         it.mult = 8'd0;
      end
      return it;
   endfunction

   // Present one item, hold it until accepted, then predict its grant
   task automatic send_item(palette_item_t it);
      while (!no_idle && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= it.mode;
      req_red        <= it.red;
      req_green      <= it.green;
      req_blue       <= it.blue;
      req_multiplier <= it.mult;
      req_free_index <= it.free_idx;
      do
         @(posedge clock);
      while (!req_ready);
      grant_q.push_back(grant_slot(it));
      case (it.mode)
         MODE_REQUEST: n_request++;
         MODE_FREE:    n_free++;
         MODE_CLEAR:   n_clear++;
         default:      n_unused++;
      endcase
   endtask

   // Drop valid and wait until every grant has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (grant_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both registers back to back; call only while the block is idle
   task automatic load_settings(logic [9:0] tol, logic [7:0] mult);
      csr_we    <= 1'b1;
      csr_index <= CSR_MATCH_TOLERANCE;
      csr_wdata <= tol;
      @(posedge clock);
      csr_index <= CSR_DEFAULT_MULTIPLIER;
      csr_wdata <= {2'b00, mult};
      @(posedge clock);
      csr_we    <= 1'b0;
      tol_reg   = tol;
      dflt_mult = mult;
      n_settings++;
   endtask

   task automatic run_random(int count);
      repeat (count) send_item(random_item());
   endtask

   // Hand-picked items at reset settings: reuse, creation, full palette,
   // free down past zero, free of slot 0, unused mode, clear
   task automatic test_directed_cases();
      send_item('{MODE_REQUEST, 8'd255, 8'd255, 8'd255, 8'd0,   2'd0});
      send_item('{MODE_REQUEST, 8'd10,  8'd10,  8'd255, 8'd0,   2'd0});
      send_item('{MODE_REQUEST, 8'd10,  8'd10,  8'd255, 8'd28,  2'd0});
      send_item('{MODE_REQUEST, 8'd0,   8'd0,   8'd0,   8'd255, 2'd0});
      send_item('{MODE_REQUEST, 8'd255, 8'd255, 8'd255, 8'd255, 2'd3});
      // palette full: nearest slot is reused whatever the distance
      send_item('{MODE_REQUEST, 8'd0,   8'd0,   8'd1,   8'd0,   2'd0});
      send_item('{MODE_REQUEST, 8'd255, 8'd255, 8'd255, 8'd1,   2'd0});
      send_item('{MODE_REQUEST, 8'd128, 8'd64,  8'd32,  8'd200, 2'd0});
      send_item('{MODE_FREE,    8'd0,   8'd0,   8'd0,   8'd0,   2'd3});
      send_item('{MODE_FREE,    8'd255, 8'd255, 8'd255, 8'd255, 2'd3});
      send_item('{MODE_FREE,    8'd0,   8'd0,   8'd0,   8'd0,   2'd3});
      send_item('{MODE_REQUEST, 8'd128, 8'd64,  8'd32,  8'd0,   2'd0});
      send_item('{MODE_FREE,    8'd0,   8'd0,   8'd0,   8'd0,   2'd0});
      send_item('{MODE_FREE,    8'd0,   8'd0,   8'd0,   8'd0,   2'd0});
      send_item('{MODE_FREE,    8'd0,   8'd0,   8'd0,   8'd0,   2'd0});
      send_item('{MODE_UNUSED,  8'd255, 8'd255, 8'd255, 8'd255, 2'd3});
      send_item('{MODE_CLEAR,   8'd255, 8'd255, 8'd255, 8'd255, 2'd3});
      send_item('{MODE_REQUEST, 8'd10,  8'd10,  8'd255, 8'd0,   2'd0});
      send_item('{MODE_REQUEST, 8'd11,  8'd10,  8'd255, 8'd0,   2'd0});
      send_item('{MODE_FREE,    8'd0,   8'd0,   8'd0,   8'd0,   2'd1});
      send_item('{MODE_FREE,    8'd0,   8'd0,   8'd0,   8'd0,   2'd2});
      send_item('{MODE_REQUEST, 8'd0,   8'd255, 8'd0,   8'd0,   2'd1});
      drain();
   endtask

   // Zero tolerance always creates while a slot is free; full tolerance
   // never creates
   task automatic test_match_tolerance_extremes();
      load_settings(10'd0, 8'd0);
      send_item('{MODE_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0});
      send_item('{MODE_REQUEST, 8'd255, 8'd255, 8'd255, 8'd28, 2'd0});
      send_item('{MODE_REQUEST, 8'd1,   8'd2,   8'd3,   8'd0,  2'd0});
      run_random(40);
      drain();
      load_settings(10'd1023, 8'd255);
      send_item('{MODE_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0});
      send_item('{MODE_REQUEST, 8'd0, 8'd0, 8'd0, 8'd255, 2'd0});
      run_random(40);
      drain();
   endtask

   // Back-to-back items with no idling: drive counts into both limits
   task automatic test_count_saturation();
      no_idle = 1'b1;
      load_settings(10'd1023, 8'd28);
      send_item('{MODE_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0});
      repeat (270)
         send_item('{MODE_REQUEST, 8'd255, 8'd255, 8'd255, 8'd0, 2'd0});
      repeat (270)
         send_item('{MODE_FREE, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0});
      drain();
      no_idle = 1'b0;
   endtask

   // Random traffic under a spread of settings, reset values included
   task automatic test_random_traffic();
      load_settings(10'd3, 8'd28);
      run_random(150);
      drain();
      load_settings(10'($urandom_range(40)), 8'($urandom));
      run_random(150);
      drain();
      load_settings(10'd1, 8'd255);
      run_random(150);
      drain();
      load_settings(10'($urandom_range(1023)), 8'($urandom_range(1, 254)));
      run_random(150);
      drain();
      load_settings(10'($urandom_range(4, 20)), 8'd0);
      run_random(150);
      drain();
   endtask

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_mode       <= MODE_REQUEST;
      req_red        <= '0;
      req_green      <= '0;
      req_blue       <= '0;
      req_multiplier <= '0;
      req_free_index <= '0;
      csr_we         <= 1'b0;
      csr_index      <= CSR_MATCH_TOLERANCE;
      csr_wdata      <= '0;
      no_idle     = 1'b0;
      err_count   = 0;
      cycle_count = 0;
      n_request = 0; n_free = 0; n_clear = 0; n_unused = 0;
      n_created = 0; n_settings = 0;
      reset_palette();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_match_tolerance_extremes();
      test_count_saturation();
      test_random_traffic();

      $display("covered %0d requests (%0d slots created), %0d frees, %0d clears, %0d unused",
               n_request, n_created, n_free, n_clear, n_unused);
      $display("under %0d register settings, counts driven to both limits", n_settings);
      if (err_count == 0 && grant_q.size() == 0)
         $display("light_palette_match_allocator test passed");
      else
         $display("light_palette_match_allocator test failed");
      $finish;
   end

endmodule
